/* sv/fms_pkg.sv */
// Shared types, constants and the sine table builder for the three-operator FM synthesizer.
package fms_pkg;

	localparam int SINE_INDEX_BITS = 10;
	localparam int PHASE_BITS = 32;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int SAMPLE_W = 16;
	localparam int STEP_W = 32;
	localparam int DEPTH_W = 31;

	typedef enum logic [2:0] {
		REG_CARRIER_STEP = 3'd0,
		REG_MODULATOR_STEP = 3'd1,
		REG_LFO_STEP = 3'd2,
		REG_LFO_TO_CARRIER_DEPTH = 3'd3,
		REG_MOD_TO_CARRIER_DEPTH = 3'd4,
		REG_LFO_TO_MOD_DEPTH = 3'd5
	} fms_reg_t;

	typedef struct packed {
		logic [STEP_W-1:0] carrier_step;
		logic [STEP_W-1:0] modulator_step;
		logic [STEP_W-1:0] lfo_step;
		logic [DEPTH_W-1:0] lfo_to_carrier_depth;
		logic [DEPTH_W-1:0] modulator_to_carrier_depth;
		logic [DEPTH_W-1:0] lfo_to_modulator_depth;
	} fms_cfg_t;

	localparam logic [63:0] Q30_ONE = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] FULL_SCALE = 64'd32767;

	// Quarter-wave sine magnitude for table entry k, evaluated only on constants.
	// An 11th-degree Taylor series in unsigned Q30, rounded to a 32767 full scale.
	function automatic logic [63:0] quarter_sine(input logic [63:0] k, input int sib);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		x = (k * HALF_PI_Q30) >> (sib - 2);
		x2 = (x * x) >> 30;
		t = Q30_ONE - x2 / 64'd110;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
		s = (x * t) >> 30;
		if (s > Q30_ONE) begin
			s = Q30_ONE;
		end
		return (s * FULL_SCALE + (64'd1 << 29)) >> 30;
	endfunction

endpackage

/* sv/fms_sine_rom.sv */
// Quarter-wave sine table with a registered read and sign restore for one oscillator.
module fms_sine_rom #(
	parameter int SINE_INDEX_BITS = fms_pkg::SINE_INDEX_BITS
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic [SINE_INDEX_BITS-1:0]           idx,
	output logic signed [fms_pkg::SAMPLE_W-1:0]  sine
);

	localparam int QW = SINE_INDEX_BITS - 2;
	localparam int QUARTER = 1 << QW;
	localparam int AW = QW + 1;

	logic [fms_pkg::SAMPLE_W-1:0] rom_tbl [QUARTER+1];
	logic [AW-1:0] addr;
	logic [fms_pkg::SAMPLE_W-1:0] mag_q;
	logic neg_q;

	for (genvar i = 0; i <= QUARTER; i++) begin : g_tbl
		localparam logic [63:0] VAL = fms_pkg::quarter_sine(64'(i), SINE_INDEX_BITS);
		assign rom_tbl[i] = VAL[fms_pkg::SAMPLE_W-1:0];
	end

	// The second and fourth quadrants read the table backwards.
	always_comb begin
		if (idx[QW]) begin
			addr = AW'(QUARTER) - {1'b0, idx[QW-1:0]};
		end else begin
			addr = {1'b0, idx[QW-1:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_q <= rom_tbl[addr];
			neg_q <= idx[SINE_INDEX_BITS-1];
		end
	end

	assign sine = neg_q ? -$signed(mag_q) : $signed(mag_q);

endmodule

/* sv/fms_cfg_regs.sv */
// APB-style configuration registers for the oscillator steps and modulation depths.
module fms_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fms_pkg::ADDR_W-1:0]    paddr,
	input  logic [fms_pkg::DATA_W-1:0]    pwdata,
	output logic [fms_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	output fms_pkg::fms_cfg_t             cfg
);

	fms_pkg::fms_cfg_t cfg_q;
	fms_pkg::fms_reg_t reg_sel;
	logic wr_en;

	assign pready = 1'b1;
	assign reg_sel = fms_pkg::fms_reg_t'(paddr[fms_pkg::ADDR_W-1:2]);
	assign wr_en = psel && penable && pwrite && pready;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_sel)
				fms_pkg::REG_CARRIER_STEP: cfg_q.carrier_step <= pwdata;
				fms_pkg::REG_MODULATOR_STEP: cfg_q.modulator_step <= pwdata;
				fms_pkg::REG_LFO_STEP: cfg_q.lfo_step <= pwdata;
				fms_pkg::REG_LFO_TO_CARRIER_DEPTH:
					cfg_q.lfo_to_carrier_depth <= pwdata[fms_pkg::DEPTH_W-1:0];
				fms_pkg::REG_MOD_TO_CARRIER_DEPTH:
					cfg_q.modulator_to_carrier_depth <= pwdata[fms_pkg::DEPTH_W-1:0];
				fms_pkg::REG_LFO_TO_MOD_DEPTH:
					cfg_q.lfo_to_modulator_depth <= pwdata[fms_pkg::DEPTH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			fms_pkg::REG_CARRIER_STEP: prdata = cfg_q.carrier_step;
			fms_pkg::REG_MODULATOR_STEP: prdata = cfg_q.modulator_step;
			fms_pkg::REG_LFO_STEP: prdata = cfg_q.lfo_step;
			fms_pkg::REG_LFO_TO_CARRIER_DEPTH: prdata = {1'b0, cfg_q.lfo_to_carrier_depth};
			fms_pkg::REG_MOD_TO_CARRIER_DEPTH:
				prdata = {1'b0, cfg_q.modulator_to_carrier_depth};
			fms_pkg::REG_LFO_TO_MOD_DEPTH: prdata = {1'b0, cfg_q.lfo_to_modulator_depth};
			default: prdata = '0;
		endcase
	end

endmodule

/* sv/fms_phase_update.sv */
// Multiply-add phase advance: scales the sines by their depths and sums them into new phases.
module fms_phase_update #(
	parameter int PHASE_BITS = fms_pkg::PHASE_BITS
) (
	input  fms_pkg::fms_cfg_t                    cfg,
	input  logic [PHASE_BITS-1:0]                carrier_phase,
	input  logic [PHASE_BITS-1:0]                modulator_phase,
	input  logic [PHASE_BITS-1:0]                lfo_phase,
	input  logic signed [fms_pkg::SAMPLE_W-1:0]  modulator_sine,
	input  logic signed [fms_pkg::SAMPLE_W-1:0]  lfo_sine,
	output logic [PHASE_BITS-1:0]                carrier_next,
	output logic [PHASE_BITS-1:0]                modulator_next,
	output logic [PHASE_BITS-1:0]                lfo_next
);

	localparam int PROD_W = fms_pkg::SAMPLE_W + fms_pkg::DEPTH_W + 1;

	logic signed [PROD_W-1:0] mod_to_car_prod;
	logic signed [PROD_W-1:0] lfo_to_car_prod;
	logic signed [PROD_W-1:0] lfo_to_mod_prod;

	always_comb begin
		mod_to_car_prod = PROD_W'(modulator_sine)
			* PROD_W'($signed({1'b0, cfg.modulator_to_carrier_depth}));
		lfo_to_car_prod = PROD_W'(lfo_sine)
			* PROD_W'($signed({1'b0, cfg.lfo_to_carrier_depth}));
		lfo_to_mod_prod = PROD_W'(lfo_sine)
			* PROD_W'($signed({1'b0, cfg.lfo_to_modulator_depth}));
	end

	// Dropping the low 15 product bits of a two's complement value floors the quotient.
	assign carrier_next = carrier_phase + cfg.carrier_step[PHASE_BITS-1:0]
		+ mod_to_car_prod[PHASE_BITS+14:15] + lfo_to_car_prod[PHASE_BITS+14:15];
	assign modulator_next = modulator_phase + cfg.modulator_step[PHASE_BITS-1:0]
		+ lfo_to_mod_prod[PHASE_BITS+14:15];
	assign lfo_next = lfo_phase + cfg.lfo_step[PHASE_BITS-1:0];

endmodule

/* sv/three_operator_fm_synth_top.sv */
// Top level of the three-operator FM synthesizer.
// Each transaction on the input channel (in_valid/in_ready, field restart) yields
// one transaction on the output channel (out_valid/out_ready, field sample), the
// sine of the carrier phase. A high restart zeroes all three phases first.
// An accepted input's sine table reads are registered in the read stage; when the
// output register is free, the multiply-add then writes the phases back as the
// carrier sine is loaded into the output register. The read stage takes no new input
// until those phases are written, since the next sample reads them.
// The output register lets a new input be taken while a finished sample waits.
// If the receiver stalls further, the sample in flight holds in the read stage
// and in_ready stays low until the output register drains.
// Reset clears the phases, the configuration registers and both valid flags.
// The user must write configuration over the APB-style port only while no sample
// is in flight; the block does not enforce this. Register i sits at byte address
// 4*i, and pready is always high.
module three_operator_fm_synth_top #(
	parameter int SINE_INDEX_BITS = fms_pkg::SINE_INDEX_BITS,
	parameter int PHASE_BITS = fms_pkg::PHASE_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [fms_pkg::ADDR_W-1:0]           paddr,
	input  logic [fms_pkg::DATA_W-1:0]           pwdata,
	output logic [fms_pkg::DATA_W-1:0]           prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 restart,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [fms_pkg::SAMPLE_W-1:0]  sample
);

	fms_pkg::fms_cfg_t cfg;

	logic accept;
	logic advance;
	logic valid_s1;
	logic out_valid_q;
	logic signed [fms_pkg::SAMPLE_W-1:0] sample_q;

	logic [PHASE_BITS-1:0] carrier_q;
	logic [PHASE_BITS-1:0] modulator_q;
	logic [PHASE_BITS-1:0] lfo_q;
	logic [PHASE_BITS-1:0] carrier_eff;
	logic [PHASE_BITS-1:0] modulator_eff;
	logic [PHASE_BITS-1:0] lfo_eff;
	logic [PHASE_BITS-1:0] carrier_s1;
	logic [PHASE_BITS-1:0] modulator_s1;
	logic [PHASE_BITS-1:0] lfo_s1;
	logic [PHASE_BITS-1:0] carrier_next;
	logic [PHASE_BITS-1:0] modulator_next;
	logic [PHASE_BITS-1:0] lfo_next;

	logic signed [fms_pkg::SAMPLE_W-1:0] carrier_sine;
	logic signed [fms_pkg::SAMPLE_W-1:0] modulator_sine;
	logic signed [fms_pkg::SAMPLE_W-1:0] lfo_sine;

	fms_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The read stage holds one sample; the next may enter only after its phases are written.
	assign in_ready = !valid_s1;
	assign accept = in_valid && in_ready;
	assign advance = valid_s1 && (!out_valid_q || out_ready);

	assign carrier_eff = restart ? '0 : carrier_q;
	assign modulator_eff = restart ? '0 : modulator_q;
	assign lfo_eff = restart ? '0 : lfo_q;

	fms_sine_rom #(.SINE_INDEX_BITS(SINE_INDEX_BITS)) u_rom_car (
		.clk  (clk),
		.en   (accept),
		.idx  (carrier_eff[PHASE_BITS-1 -: SINE_INDEX_BITS]),
		.sine (carrier_sine)
	);

	fms_sine_rom #(.SINE_INDEX_BITS(SINE_INDEX_BITS)) u_rom_mod (
		.clk  (clk),
		.en   (accept),
		.idx  (modulator_eff[PHASE_BITS-1 -: SINE_INDEX_BITS]),
		.sine (modulator_sine)
	);

	fms_sine_rom #(.SINE_INDEX_BITS(SINE_INDEX_BITS)) u_rom_lfo (
		.clk  (clk),
		.en   (accept),
		.idx  (lfo_eff[PHASE_BITS-1 -: SINE_INDEX_BITS]),
		.sine (lfo_sine)
	);

	fms_phase_update #(.PHASE_BITS(PHASE_BITS)) u_update (
		.cfg             (cfg),
		.carrier_phase   (carrier_s1),
		.modulator_phase (modulator_s1),
		.lfo_phase       (lfo_s1),
		.modulator_sine  (modulator_sine),
		.lfo_sine        (lfo_sine),
		.carrier_next    (carrier_next),
		.modulator_next  (modulator_next),
		.lfo_next        (lfo_next)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			carrier_s1 <= carrier_eff;
			modulator_s1 <= modulator_eff;
			lfo_s1 <= lfo_eff;
		end
		if (advance) begin
			sample_q <= carrier_sine;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			carrier_q <= '0;
			modulator_q <= '0;
			lfo_q <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				carrier_q <= carrier_next;
				modulator_q <= modulator_next;
				lfo_q <= lfo_next;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign sample = sample_q;

endmodule

/* sv/fms_checker.sv */
// Port-level checks for the three-operator FM synthesizer, bound to the top level.
module fms_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 restart,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic signed [fms_pkg::SAMPLE_W-1:0]  sample
);

	// A stalled sample stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample))
		else $error("output sample dropped or changed while stalled");

	// Only one transaction may be in the phase loop at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while the previous transaction is still in flight");

	// A restart with a free output yields a zero sample.
	a_restart_zero: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && restart && (!out_valid || out_ready)
		|-> ##2 (out_valid && sample == 16'sd0))
		else $error("restart did not produce a zero sample on time");

	// The sine table never reaches the most negative code.
	a_sample_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sample != -16'sd32768)
		else $error("sample outside the table range");

endmodule

bind three_operator_fm_synth_top fms_checker u_fms_checker (.*);
